>>> rtl/led_pixel_frame_serializer_top_assert.svh
// Assertion macros for the LED pixel frame serialiser checker.
// Used by lpfs_checker.sv; no other dependencies.
`ifndef LED_PIXEL_FRAME_SERIALIZER_TOP_ASSERT_SVH
`define LED_PIXEL_FRAME_SERIALIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define LPFS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lpfs assertion failed");

// Next-cycle implication, disabled while reset is held
`define LPFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lpfs assertion failed");

// Next-cycle implication that also holds across reset
`define LPFS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lpfs assertion failed");

`endif

>>> rtl/lpfs_pkg.sv
// Shared types, constants and the gamma table of the LED pixel frame serialiser.
// No dependencies.
`timescale 1ns / 1ps

package lpfs_pkg;

    // Strip size limit and derived column limit
    localparam int MAX_LEDS   = 256;
    localparam int COL_LIMIT  = (MAX_LEDS < 256) ? MAX_LEDS : 256;

    // Field widths
    localparam int LED_COUNT_W = 9;
    localparam int BRIGHT_W    = 5;
    localparam int POS_W       = 8;
    localparam int GAMMA_W     = 6;
    localparam int SEQ_POS_W   = 5;
    localparam int TAIL_W      = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT         = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_BRIGHTNESS = 1'd1;

    // Reset values
    localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 9'd256;
    localparam logic [BRIGHT_W-1:0]    BRIGHT_RST    = 5'd31;

    // Byte codes
    localparam logic [7:0] START_BYTE = 8'h00;
    localparam logic [7:0] HDR_MARK   = 8'hE0;
    localparam logic [7:0] END_BYTE   = 8'hFF;

    // Positions within one item's byte run
    localparam logic [SEQ_POS_W-1:0] SEQ_START  = 5'd0;
    localparam logic [SEQ_POS_W-1:0] SEQ_HEADER = 5'd4;
    localparam logic [SEQ_POS_W-1:0] SEQ_BLUE   = 5'd5;
    localparam logic [SEQ_POS_W-1:0] SEQ_GREEN  = 5'd6;
    localparam logic [SEQ_POS_W-1:0] SEQ_RED    = 5'd7;
    localparam logic [SEQ_POS_W-1:0] SEQ_END    = 5'd8;

    // Gamma thresholds: output rises by one at each of these inputs
    localparam int GAMMA_STEP_COUNT = 51;
    localparam logic [7:0] GAMMA_STEPS [GAMMA_STEP_COUNT] = '{
        8'd46,  8'd70,  8'd84,  8'd95,  8'd104, 8'd112, 8'd119, 8'd126, 8'd132, 8'd137,
        8'd143, 8'd147, 8'd152, 8'd156, 8'd161, 8'd165, 8'd168, 8'd172, 8'd176, 8'd179,
        8'd182, 8'd186, 8'd189, 8'd192, 8'd195, 8'd198, 8'd201, 8'd203, 8'd206, 8'd209,
        8'd211, 8'd214, 8'd216, 8'd219, 8'd221, 8'd223, 8'd226, 8'd228, 8'd230, 8'd232,
        8'd235, 8'd237, 8'd239, 8'd241, 8'd243, 8'd245, 8'd247, 8'd249, 8'd251, 8'd253,
        8'd255
    };

    // Constant 256-entry gamma ROM: count of thresholds at or below x
    function automatic logic [GAMMA_W-1:0] gamma_lookup(input logic [7:0] x);
        logic [GAMMA_W-1:0] n;
        n = '0;
        for (int i = 0; i < GAMMA_STEP_COUNT; i++) begin
            if (x >= GAMMA_STEPS[i]) begin
                n = GAMMA_W'(i + 1);
            end
        end
        return n;
    endfunction

    // One pixel item as handed to the byte sequencer
    typedef struct packed {
        logic                  col_start;
        logic                  col_end;
        logic [TAIL_W-1:0]     tail;
        logic [BRIGHT_W-1:0]   bright;
        logic [GAMMA_W-1:0]    blue;
        logic [GAMMA_W-1:0]    green;
        logic [GAMMA_W-1:0]    red;
    } pixel_item_t;

endpackage

>>> rtl/lpfs_byte_seq.sv
// Byte sequencer: holds one pixel item and emits its bytes through an output register.
// Depends on lpfs_pkg.
`timescale 1ns / 1ps

module lpfs_byte_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lpfs_pkg::pixel_item_t in_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // out_byte[7:0]
    output logic                 m_tlast,   // last_of_run
    output logic                 m_tuser    // column_done
);

    lpfs_pkg::pixel_item_t                item_reg;
    logic                                 item_valid_reg;
    logic [lpfs_pkg::SEQ_POS_W-1:0]       pos_reg;
    logic [7:0]                           tdata_reg;
    logic                                 tlast_reg;
    logic                                 tuser_reg;
    logic                                 tvalid_reg;

    logic                                 out_free;
    logic                                 emit;
    logic                                 is_last;
    logic                                 load;
    logic [lpfs_pkg::SEQ_POS_W-1:0]       last_pos;
    logic [lpfs_pkg::SEQ_POS_W-1:0]       first_pos;
    logic [7:0]                           byte_next;

    // Run bounds of the held item
    assign last_pos  = item_reg.col_end
                     ? lpfs_pkg::SEQ_POS_W'(lpfs_pkg::SEQ_RED + item_reg.tail)
                     : lpfs_pkg::SEQ_RED;
    assign first_pos = in_item.col_start ? lpfs_pkg::SEQ_START : lpfs_pkg::SEQ_HEADER;

    // Handshake: a new item may enter as the last byte of the current one leaves
    assign out_free = !tvalid_reg || m_tready;
    assign emit     = item_valid_reg && out_free;
    assign is_last  = (pos_reg == last_pos);
    assign in_ready = !item_valid_reg || (emit && is_last);
    assign load     = in_valid && in_ready;

    // Byte selection by position in the run
    always_comb begin
        if (pos_reg < lpfs_pkg::SEQ_HEADER) begin
            byte_next = lpfs_pkg::START_BYTE;
        end else if (pos_reg >= lpfs_pkg::SEQ_END) begin
            byte_next = lpfs_pkg::END_BYTE;
        end else begin
            case (pos_reg)
                lpfs_pkg::SEQ_HEADER: byte_next = lpfs_pkg::HDR_MARK | {3'b000, item_reg.bright};
                lpfs_pkg::SEQ_BLUE:   byte_next = {2'b00, item_reg.blue};
                lpfs_pkg::SEQ_GREEN:  byte_next = {2'b00, item_reg.green};
                default:              byte_next = {2'b00, item_reg.red};
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            tvalid_reg     <= 1'b0;
        end else begin
            if (emit) begin
                tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                tvalid_reg <= 1'b0;
            end
            if (load) begin
                item_valid_reg <= 1'b1;
            end else if (emit && is_last) begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            tdata_reg <= byte_next;
            tlast_reg <= is_last;
            tuser_reg <= (pos_reg >= lpfs_pkg::SEQ_END);
        end
    end

    // Held item and run position; a new item restarts the run
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= in_item;
            pos_reg  <= first_pos;
        end else if (emit) begin
            pos_reg  <= pos_reg + 1'b1;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

endmodule

>>> rtl/led_pixel_frame_serializer_top.sv
// LED pixel frame serialiser: takes one RGB pixel per item and emits the serial
// byte stream for an addressable LED strip column, one byte per item on the
// master side. A column opens with four 0x00 bytes; each pixel gives a header
// 0xE0 | global_brightness and gamma-corrected blue, green, red; after pixel n =
// led_count (zero acting as one, capped at 256) come floor((n+23)/16) bytes of 0xFF
// (tuser high) and the count restarts. Rate: one output byte per cycle from the
// output register while m_tready is high; a pixel gives 4 bytes, 8 when it opens
// a column, plus 1..17 when it closes one. The next pixel is taken in the cycle
// its predecessor's last byte is registered. Depends on lpfs_pkg and lpfs_byte_seq.
`timescale 1ns / 1ps

module led_pixel_frame_serializer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [lpfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Pixel input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,  // red[7:0], green[15:8], blue[23:16]
    // Byte output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // out_byte[7:0]
    output logic                              m_tlast,  // last_of_run
    output logic                              m_tuser   // column_done
);

    logic [lpfs_pkg::LED_COUNT_W-1:0] led_count_reg;
    logic [lpfs_pkg::BRIGHT_W-1:0]    bright_reg;
    logic [lpfs_pkg::POS_W-1:0]       pixel_pos_reg;

    logic [lpfs_pkg::LED_COUNT_W-1:0] eff_len;
    logic [lpfs_pkg::LED_COUNT_W:0]   tail_sum;
    logic [lpfs_pkg::LED_COUNT_W-1:0] pos_plus;
    logic                             col_end;
    logic                             s_accept;
    lpfs_pkg::pixel_item_t            item;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg <= lpfs_pkg::LED_COUNT_RST;
            bright_reg    <= lpfs_pkg::BRIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lpfs_pkg::REG_LED_COUNT:         led_count_reg <= cfg_wdata;
                lpfs_pkg::REG_GLOBAL_BRIGHTNESS: bright_reg    <= cfg_wdata[lpfs_pkg::BRIGHT_W-1:0];
            endcase
        end
    end

    // Effective column length: zero acts as one, large values saturate
    always_comb begin
        if (led_count_reg == '0) begin
            eff_len = lpfs_pkg::LED_COUNT_W'(1);
        end else if (led_count_reg > lpfs_pkg::LED_COUNT_W'(lpfs_pkg::COL_LIMIT)) begin
            eff_len = lpfs_pkg::LED_COUNT_W'(lpfs_pkg::COL_LIMIT);
        end else begin
            eff_len = led_count_reg;
        end
    end

    assign tail_sum = {1'b0, eff_len} + (lpfs_pkg::LED_COUNT_W + 1)'(23);
    assign pos_plus = {1'b0, pixel_pos_reg} + 1'b1;
    assign col_end  = (pos_plus >= eff_len);
    assign s_accept = s_tvalid && s_tready;

    // Item built at the input: gamma ROM lookups and column framing
    always_comb begin
        item.col_start = (pixel_pos_reg == '0);
        item.col_end   = col_end;
        item.tail      = tail_sum[4 +: lpfs_pkg::TAIL_W];
        item.bright    = bright_reg;
        item.red       = lpfs_pkg::gamma_lookup(s_tdata[7:0]);
        item.green     = lpfs_pkg::gamma_lookup(s_tdata[15:8]);
        item.blue      = lpfs_pkg::gamma_lookup(s_tdata[23:16]);
    end

    // Column position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_pos_reg <= '0;
        end else if (s_accept) begin
            pixel_pos_reg <= col_end ? '0 : pos_plus[lpfs_pkg::POS_W-1:0];
        end
    end

    lpfs_byte_seq u_byte_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> rtl/lpfs_checker.sv
// Port-level checker for the LED pixel frame serialiser, bound to the top level.
// Depends on led_pixel_frame_serializer_top_assert.svh.
`timescale 1ns / 1ps
`include "led_pixel_frame_serializer_top_assert.svh"

module lpfs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // End-frame bytes are always all ones
    `LPFS_ASSERT_NOW(a_end_byte, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 8'hFF)

    // Other bytes are start zeros, a header or a gamma value of at most 51
    `LPFS_ASSERT_NOW(a_data_byte, aclk, aresetn, m_tvalid && !m_tuser, (m_tdata <= 8'd51) || (m_tdata[7:5] == 3'b111))

    // A stalled byte stays put
    `LPFS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // No output straight after reset
    `LPFS_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid)

endmodule

bind led_pixel_frame_serializer_top lpfs_checker u_lpfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

>>> dv/led_pixel_frame_serializer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the LED pixel frame serialiser: tracks register writes and pixel items,
// predicts the serial byte stream and compares every output item against it.
// Depends on lpfs_pkg for widths, register indexes and byte codes.

module led_pixel_frame_serializer_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lpfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [7:0]                        m_tdata,   // out_byte[7:0]
    input  logic                              m_tlast,
    input  logic                              m_tuser,
    output int                                error_count,
    output int                                awaiting,
    output int                                bytes_checked,
    output int                                columns_closed
);
    import lpfs_pkg::*;

    localparam int MAX_REPORTS = 25;

    // One predicted serial byte with its sideband flags
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       col_end;
    } serial_out_t;

    serial_out_t          serial_bytes_due[$];
    logic [5:0]           gamma_rom [256];
    logic [LED_COUNT_W-1:0] strip_len;
    logic [BRIGHT_W-1:0]  brightness;
    logic [POS_W-1:0]     led_pos;

    // Gamma table worked out afresh: round(51 * (i/255)^2.7)
    initial begin
        for (int i = 0; i < 256; i++) begin
            gamma_rom[i] = 6'($rtoi(51.0 * ((i / 255.0) ** 2.7) + 0.5));
        end
        error_count    = 0;
        awaiting       = 0;
        bytes_checked  = 0;
        columns_closed = 0;
        strip_len      = LED_COUNT_RST;
        brightness     = BRIGHT_RST;
        led_pos        = '0;
    end

    // Column length as the block uses it: zero acts as one, large values saturate
    function automatic logic [LED_COUNT_W-1:0] column_length();
        if (strip_len == '0) return 9'd1;
        if (strip_len > COL_LIMIT) return 9'(COL_LIMIT);
        return strip_len;
    endfunction

    function automatic void queue_byte(input logic [7:0] d, input logic l, input logic c);
        serial_out_t e;
        e.data    = d;
        e.last    = l;
        e.col_end = c;
        serial_bytes_due.push_back(e);
    endfunction

    // Bytes caused by one pixel: start frame when it opens a column, LED frame, end frame when it closes one
    task automatic predict_pixel(input logic [23:0] px);
        logic [LED_COUNT_W-1:0] eff;
        logic [LED_COUNT_W-1:0] nxt;
        logic                   closes;
        int                     tail;
        eff    = column_length();
        nxt    = {1'b0, led_pos} + 9'd1;
        closes = (nxt >= eff);
        if (led_pos == '0) begin
            repeat (4) queue_byte(START_BYTE, 1'b0, 1'b0);
        end
        queue_byte(HDR_MARK | {3'b000, brightness}, 1'b0, 1'b0);
        queue_byte({2'b00, gamma_rom[px[23:16]]}, 1'b0, 1'b0);
        queue_byte({2'b00, gamma_rom[px[15:8]]}, 1'b0, 1'b0);
        queue_byte({2'b00, gamma_rom[px[7:0]]}, !closes, 1'b0);
        if (closes) begin
            tail = (eff + 23) >> 4;
            for (int t = 0; t < tail; t++) begin
                queue_byte(END_BYTE, t == tail - 1, 1'b1);
            end
            led_pos = '0;
        end else begin
            led_pos = nxt[POS_W-1:0];
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_REPORTS) begin
            $display("%0t ns: lpfs mismatch on %s: got %0h, wanted %0h", $time, what, got, want);
        end
        error_count++;
    endtask

    // Follow both channels and the register port at every clock edge
    always @(posedge aclk) begin
        serial_out_t want;
        if (!aresetn) begin
            strip_len  = LED_COUNT_RST;
            brightness = BRIGHT_RST;
            led_pos    = '0;
            serial_bytes_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_LED_COUNT) begin
                    strip_len = cfg_wdata[LED_COUNT_W-1:0];
                end else if (cfg_index == REG_GLOBAL_BRIGHTNESS) begin
                    brightness = cfg_wdata[BRIGHT_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                predict_pixel(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (serial_bytes_due.size() == 0) begin
                    report_mismatch("unexpected out_byte", m_tdata, 0);
                end else begin
                    want = serial_bytes_due.pop_front();
                    if (m_tdata !== want.data) report_mismatch("out_byte", m_tdata, want.data);
                    if (m_tlast !== want.last) report_mismatch("last_of_run", m_tlast, want.last);
                    if (m_tuser !== want.col_end) begin
                        report_mismatch("column_done", m_tuser, want.col_end);
                    end
                    bytes_checked++;
                    if (want.col_end && want.last) columns_closed++;
                end
            end
        end
        awaiting = serial_bytes_due.size();
    end

endmodule

>>> dv/led_pixel_frame_serializer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the LED pixel frame serialiser: clock, reset, pixel and register
// stimulus, random back-pressure and the verdict. Depends on lpfs_pkg, the DUT and
// led_pixel_frame_serializer_checker.

module led_pixel_frame_serializer_top_tb;
    import lpfs_pkg::*;

    localparam int  LONG_HOLD    = 300;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  RANDOM_ITEMS = 40;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [23:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    int error_count;
    int awaiting;
    int bytes_checked;
    int columns_closed;
    int pixels_sent;
    int hold_requests;
    int send_calm;

    led_pixel_frame_serializer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    led_pixel_frame_serializer_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .error_count    (error_count),
        .awaiting       (awaiting),
        .bytes_checked  (bytes_checked),
        .columns_closed (columns_closed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Colour level biased towards the extremes and the first gamma step
    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        if (r == 2) return 8'd45;
        if (r == 3) return 8'd46;
        return 8'($urandom);
    endfunction

    // Offer one pixel item; called at a rising edge, returns after the edge it is taken and any idle gap
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        s_tdata  <= {b, g, r};
        s_tvalid <= 1'b1;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        pixels_sent++;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(99) < 4) send_calm = $urandom_range(40, 15);
            gap = gap_len();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait for every predicted byte to come out
    task automatic end_phase();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (awaiting != 0);
        @(posedge aclk);
    endtask

    // Both registers, written back to back while the block is idle
    task automatic set_strip(input logic [8:0] count, input logic [8:0] bright_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LED_COUNT;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_index <= REG_GLOBAL_BRIGHTNESS;
        cfg_wdata <= bright_word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: random ready with calm stretches, and one long hold on request
    initial begin
        int gap;
        int calm;
        int holds_done;
        calm       = 0;
        holds_done = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (holds_done != hold_requests) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (calm > 0) begin
                    calm--;
                    gap = 0;
                end else begin
                    if ($urandom_range(99) < 4) calm = $urandom_range(60, 20);
                    gap = gap_len();
                end
                if (gap == 0) begin
                    m_tready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int          r;
        int          phase_len;
        int          random_sent;
        logic [8:0]  count;
        pixels_sent   = 0;
        hold_requests = 0;
        send_calm     = 0;
        random_sent   = 0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_LED_COUNT;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: all-zero and all-one pixels, gamma step edges
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd45, 8'd46, 8'd254);
        send_pixel(8'd255, 8'd0, 8'd46);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'h55, 8'hAA, 8'h55);
        end_phase();

        // Zero length, which also shrinks the open column; brightness off
        set_strip(9'd0, 9'd0);
        send_pixel(8'd10, 8'd200, 8'd90);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd128, 8'd255);
        end_phase();

        // Short columns; brightness word with upper bits set
        set_strip(9'd3, 9'h1F5);
        repeat (5) send_pixel(pick_level(), pick_level(), pick_level());
        end_phase();
        set_strip(9'd2, 9'd10);
        repeat (2) send_pixel(pick_level(), pick_level(), pick_level());
        end_phase();
        set_strip(9'd1, 9'd31);
        send_pixel(8'd127, 8'd128, 8'd129);
        end_phase();

        // Oversized length saturates: one full column, with a long output hold
        set_strip(9'h1FF, 9'd31);
        for (int k = 0; k < COL_LIMIT; k++) begin
            if (k == 40) hold_requests++;
            send_pixel(pick_level(), pick_level(), pick_level());
        end
        end_phase();

        // Random phases, mostly short columns
        while (random_sent < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 55)      count = 9'($urandom_range(12, 1));
            else if (r < 70) count = 9'd0;
            else if (r < 85) count = 9'($urandom_range(40, 13));
            else             count = 9'($urandom_range(511, 257));
            set_strip(count, 9'($urandom));
            phase_len = $urandom_range(14, 3);
            repeat (phase_len) send_pixel(pick_level(), pick_level(), pick_level());
            random_sent += phase_len;
            end_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d pixels, %0d bytes compared, %0d columns closed.",
                 pixels_sent, bytes_checked, columns_closed);
        $display("Lengths zero, short, full and saturated; brightness 0 to 31; long output hold.");
        if (error_count == 0) begin
            $display("led_pixel_frame_serializer_top_tb: done, clean");
        end else begin
            $display("led_pixel_frame_serializer_top_tb: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(64'd15_000_000);
        $display("Timed out with %0d bytes still awaited.", awaiting);
        $display("led_pixel_frame_serializer_top_tb: done, errors");
        $finish;
    end

endmodule

>>> led_pixel_frame_serializer_top.f
+incdir+rtl
rtl/lpfs_pkg.sv
rtl/lpfs_byte_seq.sv
rtl/led_pixel_frame_serializer_top.sv
rtl/lpfs_checker.sv
dv/led_pixel_frame_serializer_checker.sv
dv/led_pixel_frame_serializer_top_tb.sv
